// ===== src/htbd_pkg.sv =====
// shared types and constants for the huffman tree bit decoder
package htbd_pkg;

    localparam int TREE_NODES = 512;
    localparam int TREE_AW    = $clog2(TREE_NODES);
    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;
    localparam int BYTE_BITS  = 8;
    localparam int CNT_W      = 4;
    localparam int BIT_W      = 3;

    localparam logic KIND_NODE = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic             is_leaf;
        logic [SYM_W-1:0] leaf_symbol;
        logic [SYM_W-1:0] data_byte;
        logic             final_byte;
    } t_in_word;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             run_end;
    } t_out_word;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] symbol;
    } t_node;

    typedef struct packed {
        logic             node_wr;
        logic             start;
        logic             step;
        logic             resolve;
        logic             flush;
        logic [BIT_W-1:0] bit_idx;
    } t_cmd;

    typedef struct packed {
        logic stall;
        logic pend_valid;
    } t_sts;

endpackage

// ===== src/htbd_dpath.sv =====
// datapath: tree table, walk position, pending symbol and output register
module htbd_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htbd_pkg::t_cmd     i_cmd,
    output htbd_pkg::t_sts     o_sts,
    input  htbd_pkg::t_in_word i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output htbd_pkg::t_out_word o_out
);

    typedef enum logic [2:0] {
        STEP_LOAD  = 3'b001,
        STEP_CHILD = 3'b010,
        STEP_ROOT  = 3'b100
    } t_step;

    htbd_pkg::t_node mem [htbd_pkg::TREE_NODES];
    htbd_pkg::t_node r_rdata;
    htbd_pkg::t_node r_root;
    htbd_pkg::t_node cur;
    htbd_pkg::t_node wr_node;

    t_step r_pstep;
    logic [htbd_pkg::IDX_W-1:0]   r_pos;
    logic [htbd_pkg::IDX_W-1:0]   cur_pos;
    logic [htbd_pkg::IDX_W-1:0]   next_idx;
    logic [htbd_pkg::SYM_W-1:0]   r_byte;
    logic                         r_final;
    logic                         r_pend_valid;
    logic [htbd_pkg::SYM_W-1:0]   r_pend_sym;
    logic                         r_out_valid;
    htbd_pkg::t_out_word          r_out;

    logic child_leaf;
    logic emit;
    logic next_ok;
    logic out_free;
    logic push_mid;
    logic push_end;
    logic stall;
    logic adv;
    logic wr_en;
    logic rd_en;
    logic [htbd_pkg::TREE_AW-1:0] wr_addr;
    logic [htbd_pkg::TREE_AW-1:0] rd_addr;

    always_comb begin
        child_leaf = (r_pstep == STEP_CHILD) && r_rdata.leaf;
        emit       = i_cmd.resolve && child_leaf;
        case (r_pstep)
            STEP_LOAD: begin
                cur     = r_rdata;
                cur_pos = r_pos;
            end
            STEP_CHILD: begin
                cur     = r_rdata.leaf ? r_root : r_rdata;
                cur_pos = r_rdata.leaf ? '0 : r_pos;
            end
            default: begin
                cur     = r_root;
                cur_pos = '0;
            end
        endcase
        next_idx = r_byte[i_cmd.bit_idx] ? cur.right : cur.left;
        next_ok  = 32'(next_idx) < htbd_pkg::TREE_NODES;
        out_free = !r_out_valid || i_out_ready;
        push_mid = emit && r_pend_valid;
        push_end = i_cmd.flush && r_pend_valid;
        stall    = (push_mid || push_end) && !out_free;
        adv      = !stall;

        wr_node.left   = i_in.left_child;
        wr_node.right  = i_in.right_child;
        wr_node.leaf   = i_in.is_leaf;
        wr_node.symbol = i_in.leaf_symbol;
        wr_en   = i_cmd.node_wr && (32'(i_in.node_index) < htbd_pkg::TREE_NODES);
        wr_addr = htbd_pkg::TREE_AW'(i_in.node_index);
        rd_en   = i_cmd.start || (i_cmd.step && next_ok && adv);
        rd_addr = i_cmd.start ? htbd_pkg::TREE_AW'(r_pos) : htbd_pkg::TREE_AW'(next_idx);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_node;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.node_wr && (i_in.node_index == '0)) begin
            r_root <= wr_node;
        end
        if (i_cmd.start) begin
            r_byte  <= i_in.data_byte;
            r_final <= i_in.final_byte;
        end
        if (emit && adv) begin
            r_pend_sym <= r_rdata.symbol;
        end
        if ((push_mid || push_end) && adv) begin
            r_out.symbol  <= r_pend_sym;
            r_out.run_end <= push_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstep      <= STEP_ROOT;
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_pstep <= STEP_LOAD;
            end else if (i_cmd.step && adv) begin
                r_pstep <= next_ok ? STEP_CHILD : STEP_ROOT;
                r_pos   <= next_ok ? next_idx : '0;
            end else if (i_cmd.resolve && adv) begin
                r_pos <= cur_pos;
            end
            if (i_cmd.flush && adv && r_final) begin
                r_pos <= '0;
            end
            if (adv) begin
                if (emit) begin
                    r_pend_valid <= 1'b1;
                end else if (i_cmd.flush) begin
                    r_pend_valid <= 1'b0;
                end
            end
            if ((push_mid || push_end) && adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.stall      = stall;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_out_valid      = r_out_valid;
    assign o_out            = r_out;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({rd_en, wr_en}))
        else $error("table read and write in one cycle");

    a_final_to_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.flush && adv && r_final) |=> (r_pos == '0))
        else $error("walk not at root after last byte");

    a_first_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !r_pend_valid) |-> !stall)
        else $error("stall without a held symbol");

endmodule

// ===== src/htbd_ctrl.sv =====
// controller: input handshake, bit counter and sequencing state machine
module htbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  htbd_pkg::t_in_word i_in,
    input  logic               i_cfg_we,
    input  logic [htbd_pkg::CNT_W-1:0] i_cfg_wdata,
    input  htbd_pkg::t_sts     i_sts,
    output htbd_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BIT   = 4'b0010,
        S_LAST  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic [htbd_pkg::BIT_W-1:0] r_cnt;
    logic [htbd_pkg::BIT_W-1:0] n_cnt;
    logic [htbd_pkg::CNT_W-1:0] r_nbits;
    logic [htbd_pkg::CNT_W-1:0] n_nbits;
    logic [htbd_pkg::CNT_W-1:0] r_cfg;
    logic [htbd_pkg::CNT_W-1:0] last_bits;
    logic [htbd_pkg::CNT_W-1:0] byte_bits;
    logic accept;

    always_comb begin
        last_bits = (r_cfg > htbd_pkg::CNT_W'(htbd_pkg::BYTE_BITS))
                  ? htbd_pkg::CNT_W'(htbd_pkg::BYTE_BITS) : r_cfg;
        byte_bits = i_in.final_byte ? last_bits : htbd_pkg::CNT_W'(htbd_pkg::BYTE_BITS);
        accept    = i_in_valid && (r_state == S_IDLE);

        o_cmd.node_wr = accept && (i_in.kind == htbd_pkg::KIND_NODE);
        o_cmd.start   = accept && (i_in.kind == htbd_pkg::KIND_DATA);
        o_cmd.step    = (r_state == S_BIT);
        o_cmd.resolve = (r_state == S_BIT) || (r_state == S_LAST);
        o_cmd.flush   = (r_state == S_FLUSH);
        o_cmd.bit_idx = r_cnt;

        n_state = r_state;
        n_cnt   = r_cnt;
        n_nbits = r_nbits;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_nbits = byte_bits;
                    n_cnt   = '0;
                    n_state = (byte_bits == '0) ? S_FLUSH : S_BIT;
                end
            end
            S_BIT: begin
                if (!i_sts.stall) begin
                    if (({1'b0, r_cnt} + 4'd1) == r_nbits) begin
                        n_state = S_LAST;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_LAST: begin
                if (!i_sts.stall) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_nbits <= '0;
            r_cfg   <= htbd_pkg::CNT_W'(htbd_pkg::BYTE_BITS);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_nbits <= n_nbits;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |-> ({1'b0, r_cnt} < r_nbits))
        else $error("bit counter past bit count");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.pend_valid)
        else $error("symbol held while idle");

endmodule

// ===== src/huffman_tree_bit_decoder_core.sv =====
// top level of the huffman tree bit decoder
// node word: written into the tree table when accepted; ready stays high
// data word with n bits (8, or the saturated last byte count): not ready
// again until the word is flushed; each bit with an in-range child index is
// one dependent tree table read, resolved from the registered read data
// output stalls hold the walk; synchronous active-low reset clears control state
module huffman_tree_bit_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  htbd_pkg::t_in_word  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output htbd_pkg::t_out_word o_out,
    input  logic                i_cfg_we,
    input  logic [htbd_pkg::CNT_W-1:0] i_cfg_wdata
);

    htbd_pkg::t_cmd cmd;
    htbd_pkg::t_sts sts;

    htbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    htbd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
